### hdl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and register indexes of the pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

   // widths fixed by the interface
   localparam int TEXT_W  = 8;
   localparam int CSR_W   = 64;
   localparam int LEN_W   = 5;
   localparam int START_W = 32;

   typedef enum logic [1:0] {
      CSR_PATTERN_LEN  = 2'd0,
      CSR_PATTERN_LOW  = 2'd1,
      CSR_PATTERN_HIGH = 2'd2
   } csr_index_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic advance;   // a text word is taken this cycle
      logic flush;     // drop all partial matches
   } cell_ctl_type;

endpackage

### hdl/kmp_pattern_matcher.sv
// ----------------------------------------------------------------------------
// kmp_pattern_matcher
// Streaming search for a pattern of up to MAX_PATTERN bytes, non-overlapping.
// ----------------------------------------------------------------------------
// The result word is registered: it appears in the cycle after its text word is accepted.
// Throughput: one text word per cycle while the result side accepts; each cell
//   compares its pattern byte and passes its prefix-match bit to the next cell on each accepted word.
// Reset: pattern length 1, pattern bytes zero, no partial match, position 0.
// A write to a pattern register flushes partial matches and keeps the position.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher
   import kmp_pkg::*;
#(
   parameter int MAX_PATTERN = 16,
   parameter int POS_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_wen,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TEXT_W-1:0]  req_text_byte,
   input  logic               req_end_of_text,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_match_found,
   output logic [START_W-1:0] rsp_match_start
);

   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [6:0] MAX_LEN = 7'(MAX_PATTERN);

   logic [LEN_W-1:0]     pat_len_ff, pat_len_in;
   logic [CSR_W-1:0]     pat_low_ff, pat_low_in;
   logic [CSR_W-1:0]     pat_high_ff, pat_high_in;
   logic                 csr_hit;

   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;

   logic                 req_fire;
   logic [6:0]           len_raw, eff_len, len_m1;
   logic [IDX_W-1:0]     len_idx;
   logic                 match_now;
   logic [POS_WIDTH-1:0] start_pos;
   logic [START_W-1:0]   start_word;

   logic [MAX_PATTERN-1:0] hit_now;
   logic [MAX_PATTERN-1:0] hit_q;
   cell_ctl_type           ctl;

   // ---------------- configuration ----------------
   always_comb begin
      pat_len_in  = pat_len_ff;
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      csr_hit     = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_PATTERN_LEN: begin
               pat_len_in = csr_wdata[LEN_W-1:0];
               csr_hit    = 1'b1;
            end
            CSR_PATTERN_LOW: begin
               pat_low_in = csr_wdata;
               csr_hit    = 1'b1;
            end
            CSR_PATTERN_HIGH: begin
               pat_high_in = csr_wdata;
               csr_hit     = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff  <= LEN_W'(1);
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
      end else begin
         pat_len_ff  <= pat_len_in;
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
      end
   end

   // zero acts as one, anything past the row acts as the full row
   always_comb begin
      len_raw = {2'b00, pat_len_ff};
      if (len_raw == 7'd0) begin
         eff_len = 7'd1;
      end else if (len_raw > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = len_raw;
      end
      len_m1  = eff_len - 7'd1;
      len_idx = len_m1[IDX_W-1:0];
   end

   // ---------------- handshake ----------------
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   // ---------------- cell row ----------------
   assign match_now   = hit_now[len_idx];
   assign ctl.advance = req_fire;
   assign ctl.flush   = csr_hit | (req_fire & (match_now | req_end_of_text));

   genvar gi;
   for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
      logic [TEXT_W-1:0] pat_byte;
      logic              prev_hit;

      if (gi < 8) begin : g_low
         assign pat_byte = pat_low_ff[8*gi +: 8];
      end else if (gi < 16) begin : g_high
         assign pat_byte = pat_high_ff[8*(gi-8) +: 8];
      end else begin : g_none
         assign pat_byte = '0;
      end

      if (gi == 0) begin : g_head
         assign prev_hit = 1'b1;
      end else begin : g_link
         assign prev_hit = hit_q[gi-1];
      end

      kmp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .text_byte (req_text_byte),
         .pat_byte  (pat_byte),
         .prev_hit  (prev_hit),
         .hit_now   (hit_now[gi]),
         .hit_q     (hit_q[gi])
      );
   end

   // ---------------- position and start ----------------
   always_comb begin
      if (pos_ff >= POS_WIDTH'(len_m1)) begin
         start_pos = pos_ff - POS_WIDTH'(len_m1);
      end else begin
         start_pos = '0;
      end
   end

   if (POS_WIDTH >= START_W) begin : g_start_trunc
      assign start_word = start_pos[START_W-1:0];
   end else begin : g_start_ext
      assign start_word = {{(START_W-POS_WIDTH){1'b0}}, start_pos};
   end

   always_comb begin
      pos_in = pos_ff;
      if (req_fire) begin
         if (req_end_of_text) begin
            pos_in = '0;
         end else if (pos_ff != '1) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = match_now;
         rsp_start_in = match_now ? start_word : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;

   // ---------------- assertions ----------------
   a_csr_flush : assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> (hit_q == '0))
      else $error("partial match survived a pattern write");

   a_match_restart : assert property (@(posedge clock) disable iff (reset)
      (req_fire && match_now) |=> (rsp_valid_ff && rsp_found_ff && hit_q == '0))
      else $error("match not reported or search not restarted");

   a_start_clear : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_start_ff == '0))
      else $error("start nonzero without a match");

   a_eot_pos : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_end_of_text) |=> (pos_ff == '0))
      else $error("position not cleared after end of text");

endmodule

### hdl/kmp_cell.sv
// ----------------------------------------------------------------------------
// kmp_cell
// One pattern position: remembers whether the pattern prefix ending at this
// position matches the text seen since the last restart.
// ----------------------------------------------------------------------------
module kmp_cell
   import kmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [TEXT_W-1:0] text_byte,
   input  logic [TEXT_W-1:0] pat_byte,
   input  logic              prev_hit,
   output logic              hit_now,
   output logic              hit_q
);

   logic hit_ff;
   logic hit_in;

   // prefix through this position extends by one byte
   assign hit_now = prev_hit & (text_byte == pat_byte);

   always_comb begin
      hit_in = hit_ff;
      if (ctl.flush) begin
         hit_in = 1'b0;
      end else if (ctl.advance) begin
         hit_in = hit_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit_q = hit_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kmp_pattern_matcher: a queue-fed driver sends text
// words, a monitor predicts each match result and checks every result word.
// ----------------------------------------------------------------------------
module testbench;
   import kmp_pkg::*;

   localparam int MAX_PATTERN = 16;
   localparam int POS_W       = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_WORDS = 1050;
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      logic [TEXT_W-1:0] text_byte;
      logic              eot;
      int unsigned       gap;
   } text_word_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
   } match_result_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               csr_wen = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [TEXT_W-1:0]  req_text_byte = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_match_found;
   logic [START_W-1:0] rsp_match_start;

   kmp_pattern_matcher #(
      .MAX_PATTERN(MAX_PATTERN),
      .POS_WIDTH(POS_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_match_found(rsp_match_found),
      .rsp_match_start(rsp_match_start)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // stimulus and scoreboard state
   text_word_type    text_queue[$];
   match_result_type expected_matches[$];
   text_word_type    staged_word;
   logic          word_staged = 1'b0;
   logic          req_accepted = 1'b0;
   int unsigned   words_queued = 0;
   int unsigned   words_taken = 0;
   int unsigned   reply_hold = 0;
   int unsigned   sender_mode = 0;
   int unsigned   receiver_mode = 0;
   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;

   // matcher model state
   logic [LEN_W-1:0] len_reg;
   logic [63:0]      pat_low_reg;
   logic [63:0]      pat_high_reg;
   int unsigned      prefix_len;
   logic [POS_W-1:0] text_pos;
   int unsigned      fallback [MAX_PATTERN];

   function automatic int unsigned active_length();
      int unsigned n;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(int unsigned i);
      if (i < 8) return pat_low_reg[8*i +: 8];
      if (i < 16) return pat_high_reg[8*(i-8) +: 8];
      return 8'h00;
   endfunction

   // standard prefix function over the active pattern
   function automatic void rebuild_fallback();
      int unsigned n;
      int unsigned k;
      logic [7:0]  c;
      n = active_length();
      k = 0;
      foreach (fallback[i]) fallback[i] = 0;
      for (int unsigned i = 1; i < n; i++) begin
         c = pattern_byte(i);
         while (k > 0 && c != pattern_byte(k)) k = fallback[k-1];
         if (c == pattern_byte(k)) k++;
         fallback[i] = k;
      end
   endfunction

   function automatic void reset_matcher_model();
      len_reg = 5'd1;
      pat_low_reg = '0;
      pat_high_reg = '0;
      prefix_len = 0;
      text_pos = '0;
      rebuild_fallback();
   endfunction

   function automatic void apply_register_write(logic [1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_PATTERN_LEN: len_reg = data[LEN_W-1:0];
         CSR_PATTERN_LOW: pat_low_reg = data;
         CSR_PATTERN_HIGH: pat_high_reg = data;
         default: return;
      endcase
      rebuild_fallback();
      prefix_len = 0;
   endfunction

   function automatic match_result_type scan_text_byte(logic [7:0] c, logic eot);
      match_result_type r;
      int unsigned   n;
      int unsigned   j;
      n = active_length();
      j = prefix_len;
      r = '0;
      if (j >= n) j = 0;
      while (j > 0 && c != pattern_byte(j)) j = fallback[j-1];
      if (c == pattern_byte(j)) j++;
      if (j == n) begin
         r.found = 1'b1;
         r.start = (text_pos >= n - 1) ? START_W'(text_pos - (n - 1)) : '0;
         j = 0;   // non-overlapping: search restarts after a hit
      end
      if (eot) begin
         prefix_len = 0;
         text_pos = '0;
      end else begin
         prefix_len = j;
         if (text_pos != '1) text_pos++;
      end
      return r;
   endfunction

   function automatic int unsigned draw_wait(int unsigned mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 13);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      endcase
   endfunction

   // driver: presents queued words, honoring each word's leading gap
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (!word_staged && text_queue.size() != 0) begin
            staged_word = text_queue.pop_front();
            word_staged = 1'b1;
         end
         if (word_staged && staged_word.gap == 0) begin
            req_valid <= 1'b1;
            req_text_byte <= staged_word.text_byte;
            req_end_of_text <= staged_word.eot;
            word_staged = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (word_staged) staged_word.gap--;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (reply_hold != 0) begin
         rsp_ready <= 1'b0;
         reply_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predicts on accepted text words, checks result words
   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         reset_matcher_model();
         req_accepted = 1'b0;
      end else begin
         if (csr_wen) apply_register_write(csr_index, csr_wdata);
         req_accepted = req_valid && req_ready;
         if (req_accepted) begin
            expected_matches.push_back(scan_text_byte(req_text_byte, req_end_of_text));
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: unexpected result word: expected none, actual found=%0b start=%0d",
                        $time, rsp_match_found, rsp_match_start);
               error_count++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_match_found !== want.found) begin
                  $display("%0t: match_found expected %0b actual %0b",
                           $time, want.found, rsp_match_found);
                  error_count++;
               end
               if (rsp_match_start !== want.start) begin
                  $display("%0t: match_start expected %0d actual %0d",
                           $time, want.start, rsp_match_start);
                  error_count++;
               end
            end
            reply_hold = draw_wait(receiver_mode);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         cycle_count++;
      end
   end

   task automatic queue_word(logic [7:0] b, logic eot);
      text_word_type w;
      w.text_byte = b;
      w.eot = eot;
      w.gap = draw_wait(sender_mode);
      text_queue.push_back(w);
      words_queued++;
   endtask

   // returns at a falling edge once every word is taken and answered
   task automatic wait_until_drained();
      @(negedge clock);
      while (words_taken != words_queued || expected_matches.size() != 0) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [7:0] pick_symbol(int unsigned alpha);
      case (alpha)
         0: return 8'($urandom);
         1: return 8'h41 + 8'($urandom_range(0, 1));
         2: return 8'h41 + 8'($urandom_range(0, 2));
         default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   initial begin
      int unsigned alpha;
      int unsigned phase_words;
      int unsigned count;
      int unsigned embed;
      int unsigned len_pick;
      logic        first_phase;
      logic [63:0] new_low;
      logic [63:0] new_high;
      logic [63:0] new_len;

      repeat (5) @(negedge clock);
      reset <= 1'b0;
      sender_mode = 1;
      receiver_mode = 1;

      // reset pattern: one zero byte
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h00, 1'b1);
      wait_until_drained();

      // longest pattern, length written with junk in the upper bits
      write_register(CSR_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
      write_register(CSR_PATTERN_LOW, '1);
      write_register(CSR_PATTERN_HIGH, '0);
      for (int i = 0; i < 16; i++) queue_word((i < 8) ? 8'hFF : 8'h00, i == 15);
      wait_until_drained();

      // self-overlapping pattern, then a write to an unused index mid-text
      write_register(CSR_PATTERN_LEN, 64'd4);
      write_register(CSR_PATTERN_LOW, 64'h0000_0000_4241_4241);
      for (int i = 0; i < 6; i++) queue_word((i % 2) ? 8'h42 : 8'h41, 1'b0);
      wait_until_drained();
      write_register(CSR_UNUSED_INDEX, {$urandom, $urandom});
      queue_word(8'h41, 1'b0);
      queue_word(8'h42, 1'b1);
      wait_until_drained();

      alpha = 0;
      first_phase = 1'b1;
      count = words_queued + RANDOM_WORDS;
      while (words_queued < count) begin
         sender_mode = $urandom_range(0, 2);
         receiver_mode = $urandom_range(0, 2);

         if (first_phase || $urandom_range(0, 2) != 0) begin
            alpha = $urandom_range(0, 3);
            for (int i = 0; i < 8; i++) begin
               new_low[8*i +: 8] = pick_symbol(alpha);
               new_high[8*i +: 8] = pick_symbol(alpha);
            end
            len_pick = $urandom_range(0, 19);
            if (len_pick < 12) len_pick = $urandom_range(1, 6);
            else if (len_pick < 16) len_pick = $urandom_range(7, 16);
            else if (len_pick == 16) len_pick = 0;
            else if (len_pick == 17) len_pick = $urandom_range(17, 31);
            else len_pick = 16;
            new_len = {$urandom, $urandom};
            new_len[LEN_W-1:0] = len_pick[LEN_W-1:0];
            if (first_phase || $urandom_range(0, 3) != 0)
               write_register(CSR_PATTERN_LOW, new_low);
            if (first_phase || $urandom_range(0, 3) != 0)
               write_register(CSR_PATTERN_HIGH, new_high);
            if (first_phase || $urandom_range(0, 3) != 0)
               write_register(CSR_PATTERN_LEN, new_len);
            if ($urandom_range(0, 7) == 0)
               write_register(CSR_UNUSED_INDEX, {$urandom, $urandom});
            first_phase = 1'b0;
         end

         // mostly whole or partial copies of the pattern, rest noise
         phase_words = $urandom_range(8, 50);
         for (int unsigned n = 0; n < phase_words; ) begin
            if ($urandom_range(0, 2) != 0) begin
               embed = active_length();
               if ($urandom_range(0, 3) == 0) embed = $urandom_range(1, embed);
               for (int unsigned i = 0; i < embed; i++)
                  queue_word(pattern_byte(i), $urandom_range(0, 24) == 0);
               n += embed;
            end else begin
               queue_word(pick_symbol(alpha), $urandom_range(0, 24) == 0);
               n++;
            end
         end
         wait_until_drained();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_matches.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
